// ----- rtl/core/source_tokenizer_macros.svh -----
// Assertion helpers used by the checker.
`ifndef SOURCE_TOKENIZER_MACROS_SVH
`define SOURCE_TOKENIZER_MACROS_SVH
// Check that a condition implies a consequence in the same cycle.
`define ST_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Check that a condition implies a consequence in the next cycle.
`define ST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

// ----- rtl/core/stok_pkg.sv -----
package stok_pkg;

  typedef enum logic [3:0] {
    M_IDLE      = 4'd0,
    M_COMMENT   = 4'd1,
    M_NAME      = 4'd2,
    M_NUM       = 4'd3,
    M_EXP_SIGN  = 4'd4,
    M_EXP_DIG   = 4'd5,
    M_STR_EMPTY = 4'd6,
    M_STR       = 4'd7,
    M_ESC_EMPTY = 4'd8,
    M_ESC       = 4'd9,
    M_SYM1      = 4'd10,
    M_SYM2      = 4'd11
  } scan_mode_t;

  localparam logic [2:0] KIND_NAME   = 3'd0;
  localparam logic [2:0] KIND_NUMBER = 3'd1;
  localparam logic [2:0] KIND_STRING = 3'd2;
  localparam logic [2:0] KIND_SYMBOL = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  localparam logic [19:0] LINE_MAX = 20'hFFFFF;
  localparam logic [15:0] COL_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       has_byte;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  char_out;
    logic        has_char;
    logic [2:0]  token_kind;
    logic        first_of_token;
    logic [19:0] begin_line;
    logic [15:0] begin_column;
    logic        last_result;
  } out_item_t;

  // One queued decision: a byte with its two lookahead bytes, or a flush marker.
  typedef struct packed {
    logic [7:0] c;
    logic [7:0] p1;
    logic [7:0] p2;
    logic       is_end;
    logic       last;
  } step_t;

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic pair_match(logic [7:0] c, logic [7:0] n);
    logic r;
    r = 1'b0;
    if (n == "=" && (c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
                     c == "|" || c == "^" || c == "&" || c == "=" || c == "!" ||
                     c == "<" || c == ">")) r = 1'b1;
    if (c == "-" && n == ">") r = 1'b1;
    if (c == n && (c == "." || c == "&" || c == "|" || c == "<" || c == ">")) r = 1'b1;
    return r;
  endfunction

endpackage

// ----- rtl/core/stok_front.sv -----
module stok_front
  import stok_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     push,
  output step_t    push_step [4],
  output logic [2:0] push_count,
  input  logic     space_ok
);

  logic [7:0] la0, la1;
  logic [1:0] la_n;
  logic [7:0] q0, q1, q2;
  logic [1:0] n;
  logic       acc;

  assign in_ready = space_ok;
  assign acc = in_valid && in_ready;

  always_comb begin
    q0 = la0; q1 = la1; q2 = 8'd0;
    n = la_n;
    if (in_item.has_byte) begin
      unique case (la_n)
        2'd0: q0 = in_item.byte_in;
        2'd1: q1 = in_item.byte_in;
        default: q2 = in_item.byte_in;
      endcase
    end
    for (int i = 0; i < 4; i++) push_step[i] = '0;
    push_count = 3'd0;
    if (in_item.has_byte && la_n == 2'd2) begin
      push_step[0] = '{c: q0, p1: q1, p2: q2, is_end: 1'b0, last: 1'b0};
      push_count = 3'd1;
    end
    n = la_n + {1'b0, in_item.has_byte && la_n != 2'd2};
    if (in_item.end_of_source) begin
      // Flush the window bytes still pending, then the end marker.
      logic [7:0] w0, w1;
      w0 = (la_n == 2'd2 && in_item.has_byte) ? q1 : q0;
      w1 = (la_n == 2'd2 && in_item.has_byte) ? q2 : q1;
      if (n == 2'd2) begin
        push_step[push_count[1:0]] = '{c: w0, p1: w1, p2: 8'd0, is_end: 1'b0, last: 1'b0};
        push_step[push_count[1:0] + 2'd1] =
          '{c: w1, p1: 8'd0, p2: 8'd0, is_end: 1'b0, last: 1'b0};
        push_count = push_count + 3'd2;
      end else if (n == 2'd1) begin
        push_step[push_count[1:0]] = '{c: w0, p1: 8'd0, p2: 8'd0, is_end: 1'b0, last: 1'b0};
        push_count = push_count + 3'd1;
      end
      push_step[push_count[1:0]] = '{c: 8'd0, p1: 8'd0, p2: 8'd0, is_end: 1'b1, last: 1'b1};
      push_count = push_count + 3'd1;
    end else if (push_count != 3'd0) begin
      push_step[0].last = 1'b1;
    end
  end

  assign push = acc && push_count != 3'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      la0 <= '0; la1 <= '0; la_n <= '0;
    end else if (acc) begin
      if (in_item.end_of_source) begin
        la0 <= '0; la1 <= '0; la_n <= '0;
      end else if (in_item.has_byte) begin
        if (la_n == 2'd2) begin
          la0 <= q1; la1 <= q2;
        end else begin
          la0 <= q0; la1 <= q1;
        end
        la_n <= n;
      end
    end
  end

endmodule

// ----- rtl/core/stok_queue.sv -----
module stok_queue
  import stok_pkg::*;
#(
  parameter int Depth = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  step_t      push_step [4],
  input  logic [2:0] push_count,
  output logic       space_ok,
  output logic       pop_valid,
  input  logic       pop,
  output step_t      pop_step
);

  localparam int AW = $clog2(Depth);

  step_t         mem [Depth];
  logic [AW-1:0] wr, rd;
  logic [AW:0]   cnt;

  // Four free slots always fit the largest burst of one item.
  assign space_ok  = cnt <= (AW+1)'(Depth - 4);
  assign pop_valid = cnt != '0;
  assign pop_step  = mem[rd];

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < push_count) mem[wr + AW'(i)] <= push_step[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0; rd <= '0; cnt <= '0;
    end else begin
      if (push) wr <= wr + AW'(push_count);
      if (pop && pop_valid) rd <= rd + AW'(1);
      cnt <= cnt + (push ? (AW+1)'(push_count) : '0) - (AW+1)'(pop && pop_valid);
    end
  end

endmodule

// ----- rtl/core/stok_back.sv -----
module stok_back
  import stok_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step_valid,
  output logic      step_pop,
  input  step_t     step,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  scan_mode_t  mode, mode_next;
  logic        dot, dot_next;
  logic [19:0] line, line_next, tline, tline_next;
  logic [15:0] col, col_next, tcol, tcol_next;
  logic        pending, pend_next;

  // Per step, up to two results: an empty string, then an end token.
  logic        e0, e1;
  out_item_t   r0, r1;
  logic        consumed;
  logic        advance_c;
  logic        hold_empty;

  out_item_t   obuf;
  logic        ovalid;
  logic        can_load;

  assign can_load = !ovalid || out_ready;
  // A second pending result blocks the queue until it is loaded into the output register.
  assign consumed = step_valid && can_load && !pending;
  assign step_pop = consumed;

  function automatic out_item_t mk(logic [7:0] ch, logic h, logic [2:0] k, logic f,
                                   logic [19:0] l, logic [15:0] c);
    out_item_t o;
    o = '{char_out: ch, has_char: h, token_kind: k, first_of_token: f,
          begin_line: l, begin_column: c, last_result: 1'b0};
    return o;
  endfunction

  always_comb begin
    logic [7:0] c, p1, p2;
    logic       redo;
    c = step.c; p1 = step.p1; p2 = step.p2;
    redo = 1'b0;
    mode_next = mode; dot_next = dot;
    tline_next = tline; tcol_next = tcol;
    e0 = 1'b0; e1 = 1'b0; r0 = '0; r1 = '0;
    advance_c = 1'b0; hold_empty = 1'b0;
    if (step.is_end) begin
      if (mode == M_STR_EMPTY || mode == M_ESC_EMPTY) begin
        e0 = 1'b1; r0 = mk(8'd0, 1'b0, KIND_STRING, 1'b1, tline, tcol);
        e1 = 1'b1; r1 = mk(8'd0, 1'b0, KIND_END, 1'b1, line, col);
      end else begin
        e0 = 1'b1; r0 = mk(8'd0, 1'b0, KIND_END, 1'b1, line, col);
      end
    end else begin
      // Modes that fall back to between tokens resolve in one pass.
      advance_c = 1'b1;
      unique case (mode)
        M_COMMENT: if (c == "\n") mode_next = M_IDLE;
        M_NAME: begin
          if (is_alpha(c) || is_digit(c) || c == "_" || (c == "." && p1 != "."))
            begin e0 = 1'b1; r0 = mk(c, 1'b1, KIND_NAME, 1'b0, tline, tcol); end
          else redo = 1'b1;
        end
        M_NUM: begin
          if (is_digit(c)) begin
            e0 = 1'b1; r0 = mk(c, 1'b1, KIND_NUMBER, 1'b0, tline, tcol);
          end else if (c == "." && p1 != "." && !dot) begin
            dot_next = 1'b1; e0 = 1'b1; r0 = mk(c, 1'b1, KIND_NUMBER, 1'b0, tline, tcol);
          end else if ((c == "e" || c == "E") &&
                       (is_digit(p1) || ((p1 == "+" || p1 == "-") && is_digit(p2)))) begin
            e0 = 1'b1; r0 = mk(c, 1'b1, KIND_NUMBER, 1'b0, tline, tcol);
            mode_next = M_EXP_SIGN;
          end else redo = 1'b1;
        end
        M_EXP_SIGN: begin
          if (c == "+" || c == "-") begin
            e0 = 1'b1; r0 = mk(c, 1'b1, KIND_NUMBER, 1'b0, tline, tcol);
            mode_next = M_EXP_DIG;
          end else if (is_digit(c)) begin
            e0 = 1'b1; r0 = mk(c, 1'b1, KIND_NUMBER, 1'b0, tline, tcol);
            mode_next = M_EXP_DIG;
          end else redo = 1'b1;
        end
        M_EXP_DIG: begin
          if (is_digit(c)) begin
            e0 = 1'b1; r0 = mk(c, 1'b1, KIND_NUMBER, 1'b0, tline, tcol);
          end else redo = 1'b1;
        end
        M_STR_EMPTY, M_STR: begin
          if (c == "\"") begin
            if (mode == M_STR_EMPTY) begin
              e0 = 1'b1; r0 = mk(8'd0, 1'b0, KIND_STRING, 1'b1, tline, tcol);
            end
            mode_next = M_IDLE;
          end else if (c == "\\") begin
            mode_next = (mode == M_STR_EMPTY) ? M_ESC_EMPTY : M_ESC;
          end else begin
            e0 = 1'b1;
            r0 = mk(c, 1'b1, KIND_STRING, mode == M_STR_EMPTY, tline, tcol);
            mode_next = M_STR;
          end
        end
        M_ESC_EMPTY, M_ESC: begin
          e0 = 1'b1;
          r0 = mk((c == "n") ? 8'h0A : c, 1'b1, KIND_STRING, mode == M_ESC_EMPTY,
                  tline, tcol);
          mode_next = M_STR;
        end
        M_SYM1: begin
          e0 = 1'b1; r0 = mk(c, 1'b1, KIND_SYMBOL, 1'b0, tline, tcol); mode_next = M_IDLE;
        end
        M_SYM2: begin
          e0 = 1'b1; r0 = mk(c, 1'b1, KIND_SYMBOL, 1'b0, tline, tcol); mode_next = M_SYM1;
        end
        default: redo = 1'b1;
      endcase
      if (redo) begin
        mode_next = M_IDLE;
        if (is_space(c)) begin
        end else if (c == "/" && p1 == "/") begin
          mode_next = M_COMMENT;
        end else begin
          tline_next = line; tcol_next = col;
          if (is_alpha(c) || c == "_") begin
            e0 = 1'b1; r0 = mk(c, 1'b1, KIND_NAME, 1'b1, line, col); mode_next = M_NAME;
          end else if (is_digit(c)) begin
            e0 = 1'b1; r0 = mk(c, 1'b1, KIND_NUMBER, 1'b1, line, col);
            dot_next = 1'b0; mode_next = M_NUM;
          end else if (c == "\"") begin
            mode_next = M_STR_EMPTY;
          end else begin
            e0 = 1'b1; r0 = mk(c, 1'b1, KIND_SYMBOL, 1'b1, line, col);
            if (pair_match(c, p1))
              mode_next = ((c == "<" || c == ">") && p1 == c && p2 == "=") ? M_SYM2 : M_SYM1;
          end
        end
      end
    end
    line_next = line; col_next = col;
    if (advance_c) begin
      if (c == "\n") begin
        if (line != LINE_MAX) line_next = line + 20'd1;
        col_next = 16'd1;
      end else if (col != COL_MAX) col_next = col + 16'd1;
    end
    r0.last_result = step.last && !e1;
    r1.last_result = step.last;
    // The front marks only the step that ends an item, so its results carry it.
    hold_empty = e1;
    pend_next = hold_empty;
  end

  logic      pend;
  out_item_t pend_item;
  assign pending = pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; dot <= 1'b0; line <= 20'd1; col <= 16'd1;
      tline <= 20'd1; tcol <= 16'd1; ovalid <= 1'b0; pend <= 1'b0;
    end else begin
      if (pend && can_load) begin
        obuf <= pend_item; ovalid <= 1'b1; pend <= 1'b0;
      end else if (consumed) begin
        if (step.is_end) begin
          mode <= M_IDLE; dot <= 1'b0; line <= 20'd1; col <= 16'd1;
          tline <= 20'd1; tcol <= 16'd1;
        end else begin
          mode <= mode_next; dot <= dot_next; line <= line_next; col <= col_next;
          tline <= tline_next; tcol <= tcol_next;
        end
        if (e0) obuf <= r0;
        ovalid <= e0;
        pend <= pend_next;
        pend_item <= r1;
      end else if (can_load) begin
        ovalid <= 1'b0;
      end
    end
  end

  assign out_valid = ovalid;
  assign out_item  = obuf;

endmodule

// ----- rtl/core/source_tokenizer.sv -----
// source_tokenizer: streaming lexical scanner. Each accepted item carries at
// most one source byte; a byte is decided once the two bytes after it have
// arrived, and each kept character leaves as one result with its token kind,
// a first-of-token mark and the saturating line and column where its token
// began. An item with end_of_source flushes the window, emits an end token
// (preceded by a characterless string result for an empty string) and
// returns the scanner to its reset state. One item is taken per cycle while
// the step queue has room; the back end retires one queued step per cycle
// while its output register can be loaded, and a step that gives two results
// holds the queue until its second result is loaded. Results of an item may
// lag the item; the last one carries last_result. An item that causes no
// byte decision leaves no result at all.
module source_tokenizer
  import stok_pkg::*;
#(
  parameter int QueueDepth = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic       push, space_ok, pop_valid, pop;
  step_t      push_step [4];
  step_t      pop_step;
  logic [2:0] push_count;

  // Accept and split items into byte decisions.
  stok_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .push, .push_step, .push_count, .space_ok
  );

  // Decouple the two sides.
  stok_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst, .push, .push_step, .push_count, .space_ok,
    .pop_valid, .pop, .pop_step
  );

  // Scan state machine and output register.
  stok_back u_back (
    .clk, .rst, .step_valid(pop_valid), .step_pop(pop), .step(pop_step),
    .out_valid, .out_ready, .out_item
  );

endmodule

// ----- rtl/core/source_tokenizer_checker.sv -----
`include "source_tokenizer_macros.svh"
module source_tokenizer_checker
  import stok_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);
  `ST_ASSERT_NEXT(out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ST_ASSERT_IMPL(end_empty, clk, rst, out_valid && out_item.token_kind == KIND_END,
                  !out_item.has_char && out_item.first_of_token && out_item.last_result)
  `ST_ASSERT_IMPL(line_nz, clk, rst, out_valid,
                  out_item.begin_line != 20'd0 && out_item.begin_column != 16'd0)
  `ST_ASSERT_IMPL(str_empty, clk, rst, out_valid && !out_item.has_char,
                  out_item.token_kind == KIND_STRING || out_item.token_kind == KIND_END)
endmodule

bind source_tokenizer source_tokenizer_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .out_item
);

// ----- tb/source_tokenizer_checker.sv -----
module tb_source_tokenizer_checker
  import stok_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        errors,
  output int        pending
);

  logic [7:0]  win0, win1;
  int          win_fill;
  scan_mode_t  mode;
  logic        dot_taken;
  logic [19:0] cur_line, tok_line;
  logic [15:0] cur_col, tok_col;
  out_item_t   step_res[$];
  out_item_t   chars_due[$];

  function automatic bit digit_c(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit letter_c(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic bit blank_c(logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit sym_pair(logic [7:0] c, logic [7:0] n);
    if (n == "=" && (c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
                     c == "|" || c == "^" || c == "&" || c == "=" || c == "!" ||
                     c == "<" || c == ">")) return 1;
    if (c == "-" && n == ">") return 1;
    return c == n && (c == "." || c == "&" || c == "|" || c == "<" || c == ">");
  endfunction

  task automatic clear_scan();
    win0 = 0; win1 = 0; win_fill = 0; mode = M_IDLE; dot_taken = 0;
    cur_line = 1; cur_col = 1; tok_line = 1; tok_col = 1;
  endtask

  task automatic push_res(logic [7:0] ch, logic has, logic [2:0] kind, logic first,
                          logic [19:0] l, logic [15:0] c);
    out_item_t r;
    if (step_res.size() < 4) begin
      r = '{ch, has, kind, first, l, c, 1'b0};
      step_res = {step_res, r};
    end
  endtask

  task automatic bump(logic [7:0] c);
    if (c == 8'h0a) begin
      if (cur_line != LINE_MAX) cur_line++;
      cur_col = 1;
    end else if (cur_col != COL_MAX) begin
      cur_col++;
    end
  endtask

  task automatic decide(logic [7:0] c, logic [7:0] p1, logic [7:0] p2);
    bit again;
    again = 1;
    while (again) begin
      again = 0;
      case (mode)
        M_COMMENT: begin
          bump(c);
          if (c == 8'h0a) mode = M_IDLE;
        end
        M_NAME: begin
          if (letter_c(c) || digit_c(c) || c == "_" || (c == "." && p1 != ".")) begin
            push_res(c, 1, KIND_NAME, 0, tok_line, tok_col);
            bump(c);
          end else begin
            mode = M_IDLE; again = 1;
          end
        end
        M_NUM: begin
          if (digit_c(c)) begin
            push_res(c, 1, KIND_NUMBER, 0, tok_line, tok_col);
            bump(c);
          end else if (c == "." && p1 != "." && !dot_taken) begin
            dot_taken = 1;
            push_res(c, 1, KIND_NUMBER, 0, tok_line, tok_col);
            bump(c);
          end else if ((c == "e" || c == "E") &&
                       (digit_c(p1) || ((p1 == "+" || p1 == "-") && digit_c(p2)))) begin
            push_res(c, 1, KIND_NUMBER, 0, tok_line, tok_col);
            mode = M_EXP_SIGN;
            bump(c);
          end else begin
            mode = M_IDLE; again = 1;
          end
        end
        M_EXP_SIGN: begin
          mode = M_EXP_DIG;
          if (c == "+" || c == "-") begin
            push_res(c, 1, KIND_NUMBER, 0, tok_line, tok_col);
            bump(c);
          end else begin
            again = 1;
          end
        end
        M_EXP_DIG: begin
          if (digit_c(c)) begin
            push_res(c, 1, KIND_NUMBER, 0, tok_line, tok_col);
            bump(c);
          end else begin
            mode = M_IDLE; again = 1;
          end
        end
        M_STR_EMPTY, M_STR: begin
          if (c == 8'h22) begin
            if (mode == M_STR_EMPTY) push_res(0, 0, KIND_STRING, 1, tok_line, tok_col);
            mode = M_IDLE;
          end else if (c == 8'h5c) begin
            mode = (mode == M_STR_EMPTY) ? M_ESC_EMPTY : M_ESC;
          end else begin
            push_res(c, 1, KIND_STRING, mode == M_STR_EMPTY, tok_line, tok_col);
            mode = M_STR;
          end
          bump(c);
        end
        M_ESC_EMPTY, M_ESC: begin
          push_res((c == "n") ? 8'h0a : c, 1, KIND_STRING, mode == M_ESC_EMPTY,
                   tok_line, tok_col);
          mode = M_STR;
          bump(c);
        end
        M_SYM1: begin
          push_res(c, 1, KIND_SYMBOL, 0, tok_line, tok_col);
          mode = M_IDLE;
          bump(c);
        end
        M_SYM2: begin
          push_res(c, 1, KIND_SYMBOL, 0, tok_line, tok_col);
          mode = M_SYM1;
          bump(c);
        end
        default: begin
          mode = M_IDLE;
          if (blank_c(c)) begin
            bump(c);
          end else if (c == "/" && p1 == "/") begin
            mode = M_COMMENT;
            bump(c);
          end else begin
            tok_line = cur_line;
            tok_col = cur_col;
            if (letter_c(c) || c == "_") begin
              push_res(c, 1, KIND_NAME, 1, tok_line, tok_col);
              mode = M_NAME;
            end else if (digit_c(c)) begin
              push_res(c, 1, KIND_NUMBER, 1, tok_line, tok_col);
              dot_taken = 0;
              mode = M_NUM;
            end else if (c == 8'h22) begin
              mode = M_STR_EMPTY;
            end else begin
              push_res(c, 1, KIND_SYMBOL, 1, tok_line, tok_col);
              if (sym_pair(c, p1))
                mode = ((c == "<" || c == ">") && p1 == c && p2 == "=") ? M_SYM2 : M_SYM1;
            end
            bump(c);
          end
        end
      endcase
    end
  endtask

  task automatic scan_item(in_item_t it);
    logic [7:0] q[3];
    int n;
    step_res.delete();
    q[0] = win0; q[1] = win1; q[2] = 0;
    n = win_fill;
    if (it.has_byte) q[n++] = it.byte_in;
    if (n == 3) begin
      decide(q[0], q[1], q[2]);
      q[0] = q[1]; q[1] = q[2]; q[2] = 0; n = 2;
    end
    if (it.end_of_source) begin
      while (n > 0) begin
        decide(q[0], n > 1 ? q[1] : 8'h00, n > 2 ? q[2] : 8'h00);
        q[0] = q[1]; q[1] = q[2]; q[2] = 0;
        n--;
      end
      if (mode == M_STR_EMPTY || mode == M_ESC_EMPTY)
        push_res(0, 0, KIND_STRING, 1, tok_line, tok_col);
      push_res(0, 0, KIND_END, 1, cur_line, cur_col);
      clear_scan();
    end else begin
      win0 = q[0]; win1 = q[1]; win_fill = n;
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last_result = 1;
    chars_due = {chars_due, step_res};
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      errors = 0;
      clear_scan();
      chars_due.delete();
    end else begin
      if (in_valid && in_ready) scan_item(in_item);
      if (out_valid && out_ready) begin
        if (chars_due.size() == 0) begin
          $error("unexpected result %p", out_item);
          errors++;
        end else begin
          want = chars_due.pop_front();
          if (out_item.char_out !== want.char_out) begin
            $error("char_out expected %0h got %0h", want.char_out, out_item.char_out);
            errors++;
          end
          if (out_item.has_char !== want.has_char) begin
            $error("has_char expected %0d got %0d", want.has_char, out_item.has_char);
            errors++;
          end
          if (out_item.token_kind !== want.token_kind) begin
            $error("token_kind expected %0d got %0d", want.token_kind,
                   out_item.token_kind);
            errors++;
          end
          if (out_item.first_of_token !== want.first_of_token) begin
            $error("first_of_token expected %0d got %0d", want.first_of_token,
                   out_item.first_of_token);
            errors++;
          end
          if (out_item.begin_line !== want.begin_line) begin
            $error("begin_line expected %0d got %0d", want.begin_line,
                   out_item.begin_line);
            errors++;
          end
          if (out_item.begin_column !== want.begin_column) begin
            $error("begin_column expected %0d got %0d", want.begin_column,
                   out_item.begin_column);
            errors++;
          end
          if (out_item.last_result !== want.last_result) begin
            $error("last_result expected %0d got %0d", want.last_result,
                   out_item.last_result);
            errors++;
          end
        end
      end
    end
    pending = chars_due.size();
  end

endmodule

// ----- tb/tb_source_tokenizer.sv -----
module tb_source_tokenizer;
  import stok_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  int        errors;
  int        pending;

  // When set, neither side idles: stretches of back-to-back traffic.
  bit        no_gaps;
  int        sink_hold;

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  source_tokenizer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  tb_source_tokenizer_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .errors(errors), .pending(pending)
  );

  // Result side: after each accepted item, drop ready for a random number
  // of cycles (possibly none), then hold it high until the next item is taken.
  always @(posedge clk) begin
    int draw;
    if (rst) begin
      out_ready <= 1'b0;
      sink_hold <= 0;
    end else if (out_valid && out_ready) begin
      draw = no_gaps ? 0 : $urandom_range(0, 12);
      if (draw == 0) begin
        out_ready <= 1'b1;
      end else begin
        sink_hold <= draw - 1;
        out_ready <= 1'b0;
      end
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offer one item, hold it until the handshake, then optionally idle.
  task automatic send(logic [7:0] b, logic has, logic eos);
    int gap;
    in_valid <= 1'b1;
    in_item <= '{b, has, eos};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Send a text as bytes; optionally mark its last byte as end of source.
  task automatic send_text(string s, bit eos);
    for (int i = 0; i < s.len(); i++)
      send(s[i], 1'b1, eos && (i == s.len() - 1));
  endtask

  // Build one random token, not always well-formed, plus a separator that may be empty.
  function automatic string rand_token();
    string s;
    string syms[$] = '{"->", "..", "+=", "-=", "*=", "/=", "%=", "|=", "^=", "&=",
                       "==", "!=", "<=", ">=", "&&", "||", "<<", ">>", "<<=", ">>=",
                       "(", ";", "-", ".", "<", "#"};
    int n;
    s = "";
    case ($urandom_range(0, 6))
      0: begin
        n = $urandom_range(1, 5);
        s = {s, string'(8'($urandom_range(0, 1) ? "_" : "a" + $urandom_range(0, 25)))};
        for (int i = 0; i < n; i++)
          case ($urandom_range(0, 3))
            0: s = {s, string'(8'("0" + $urandom_range(0, 9)))};
            1: s = {s, "."};
            2: s = {s, string'(8'("A" + $urandom_range(0, 25)))};
            default: s = {s, string'(8'("a" + $urandom_range(0, 25)))};
          endcase
      end
      1: begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
        if ($urandom_range(0, 1)) begin
          if ($urandom_range(0, 3)) s = {s, "."};
          else s = {s, ".."};
        end
        if ($urandom_range(0, 1)) s = {s, "7"};
        if ($urandom_range(0, 1)) begin
          s = {s, $urandom_range(0, 1) ? "e" : "E"};
          case ($urandom_range(0, 3))
            0: s = {s, "+"};
            1: s = {s, "-"};
            default: ;
          endcase
          if ($urandom_range(0, 3)) s = {s, "42"};
        end
      end
      2: begin
        s = "\"";
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++)
          case ($urandom_range(0, 3))
            0: s = {s, "\\n"};
            1: s = {s, "\\\""};
            2: s = {s, " "};
            default: s = {s, string'(8'($urandom_range(8'h23, 8'h5b)))};
          endcase
        s = {s, "\""};
      end
      3: s = syms[$urandom_range(0, syms.size() - 1)];
      4: s = "// note ; x\n";
      default: s = "x";
    endcase
    case ($urandom_range(0, 4))
      0: s = {s, "\n"};
      1: s = {s, "\t"};
      2: s = {s, ""};
      default: s = {s, " "};
    endcase
    return s;
  endfunction

  initial begin
    int sent;
    in_valid = 1'b0;
    in_item = '0;
    no_gaps = 1'b0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed sources: extremes of the classes and the corner cases.
    send(8'h00, 1'b0, 1'b1);                    // empty source
    send(8'h41, 1'b0, 1'b0);                    // no byte: ignored
    send_text("a.b..c 1.5e+3 2.e 3..4 9E-", 1'b1);
    send_text("\"\" \"a\\n\\\"b\"", 1'b1);
    send_text("<<= >>= -> && x//c\n\ty", 1'b1);
    send(8'h00, 1'b1, 1'b0);                    // zero byte is a symbol
    send(8'hff, 1'b1, 1'b1);
    send_text("\"", 1'b1);                      // cut-off empty string
    send_text("\"\\", 1'b1);                    // cut-off empty escape
    send_text("\"ab", 1'b0);
    send(8'h00, 1'b0, 1'b1);                    // flush with no byte

    // Random part: mostly well-formed token streams, some raw noise.
    sent = 0;
    while (sent < 275) begin
      string s;
      no_gaps = ($urandom_range(0, 5) == 0);
      s = "";
      for (int t = $urandom_range(1, 8); t > 0; t--) s = {s, rand_token()};
      if ($urandom_range(0, 3) == 0) begin
        for (int i = $urandom_range(1, 8); i > 0; i--) begin
          send(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
          sent++;
        end
      end
      send_text(s, 1'b0);
      sent += s.len();
      send(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      sent++;
    end

    in_valid <= 1'b0;
    no_gaps = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/stok_pkg.sv
rtl/core/stok_front.sv
rtl/core/stok_queue.sv
rtl/core/stok_back.sv
rtl/core/source_tokenizer.sv
rtl/core/source_tokenizer_checker.sv
tb/source_tokenizer_checker.sv
tb/tb_source_tokenizer.sv
